@@ sv/tppg_pkg.sv @@
`default_nettype none

package tppg_pkg;

    // Field widths
    localparam int DIM_W     = 11;
    localparam int COORD_W   = 10;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 3;

    localparam int MAX_DIMENSION_DEF = 1024;

    // Fixed point
    localparam int FRAC_W     = 16;
    localparam int HUE_STEPS  = COORD_W + FRAC_W;   // quotient bits of x * 2^16 / w
    localparam int SQ_W       = 2 * DIM_W;          // one squared offset
    localparam int SUM_W      = SQ_W + 1;           // sum of two squares
    localparam int RATIO_W    = 17;                 // distance ratio before saturation
    localparam int DIV_STEPS  = 2 * RATIO_W;        // quotient bits of D2 * 2^32 / M2
    localparam int SQRT_STEPS = RATIO_W;
    localparam int SQRT_REM_W = RATIO_W + 3;

    localparam logic [RATIO_W-1:0] RATIO_FLOOR = 17'd98304;
    localparam logic [7:0]         ALPHA_MAX   = 8'd192;
    localparam logic [7:0]         ALPHA_FULL  = 8'd255;

    // Pipeline stage numbers, counted in registers after the accepting edge
    localparam int ST_IN           = 1;
    localparam int ST_SQ           = 2;
    localparam int ST_SUM          = 3;
    localparam int ST_DIV_END      = ST_SUM + DIV_STEPS;
    localparam int ST_ROOT_END     = ST_DIV_END + SQRT_STEPS;
    localparam int ST_ALPHA        = ST_ROOT_END + 1;
    localparam int LATENCY         = ST_ALPHA + 1;
    localparam int ST_HUE_DIV_END  = ST_IN + HUE_STEPS;
    localparam int ST_HUE_SUM      = ST_HUE_DIV_END + 1;
    localparam int ST_HUE_RAMP     = ST_HUE_SUM + 1;
    localparam int ST_HUE_RGB      = ST_HUE_RAMP + 1;

    // Pattern codes
    localparam logic [1:0] PAT_CHECKER = 2'd0;
    localparam logic [1:0] PAT_VSTRIPE = 2'd1;
    localparam logic [1:0] PAT_HSTRIPE = 2'd2;
    localparam logic [1:0] PAT_HUE     = 2'd3;

    // Pixel format codes
    localparam logic [1:0] FMT_RGB332 = 2'd0;
    localparam logic [1:0] FMT_RGB565 = 2'd1;
    localparam logic [1:0] FMT_RGB888 = 2'd2;
    localparam logic [1:0] FMT_RGBA8  = 2'd3;

    // Bytes per pixel
    localparam logic [COUNT_W-1:0] BYTES_RGB332 = 3'd1;
    localparam logic [COUNT_W-1:0] BYTES_RGB565 = 3'd2;
    localparam logic [COUNT_W-1:0] BYTES_RGB888 = 3'd3;
    localparam logic [COUNT_W-1:0] BYTES_RGBA8  = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_KIND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_COLOR = 3'd5;

    // Reset values
    localparam logic [1:0]         RST_PATTERN_KIND = PAT_CHECKER;
    localparam logic [1:0]         RST_PIXEL_FORMAT = FMT_RGBA8;
    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 11'd32;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 11'd32;
    localparam logic [COLOR_W-1:0] RST_FIRST_COLOR  = 24'hFF4040;
    localparam logic [COLOR_W-1:0] RST_SECOND_COLOR = 24'h802020;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

endpackage

`default_nettype wire

@@ sv/test_pattern_pixel_generator.sv @@
// done rises with the output register, after input, square, sum, divider, root and alpha stages.
// Throughput: one pixel per clock; busy stays low, a new coordinate may enter every cycle.
// The depth is set by the radial alpha: a 34-step divider and a 17-step square root,
// one quotient or root bit per register stage.
// Reset clears the valid pipeline and loads the register reset values; data stages do not reset.
// Each result is shown for one cycle only; the receiver cannot stall it.
`default_nettype none

module test_pattern_pixel_generator #(
    parameter int MAX_DIMENSION = tppg_pkg::MAX_DIMENSION_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tppg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tppg_pkg::COLOR_W-1:0]        cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [tppg_pkg::COORD_W-1:0]        pixel_x,
    input  logic [tppg_pkg::COORD_W-1:0]        pixel_y,
    output logic                                done,
    output logic [tppg_pkg::WORD_W-1:0]         pixel_word,
    output logic [tppg_pkg::COUNT_W-1:0]        byte_count
);

    localparam int DW  = tppg_pkg::DIM_W;
    localparam int CW  = tppg_pkg::COORD_W;
    localparam int FW  = tppg_pkg::FRAC_W;
    localparam int SW  = tppg_pkg::SUM_W;
    localparam int QW  = tppg_pkg::DIV_STEPS;
    localparam int RW  = tppg_pkg::RATIO_W;
    localparam int MW  = tppg_pkg::SQRT_REM_W;
    localparam int HS  = tppg_pkg::HUE_STEPS;
    localparam int DS  = tppg_pkg::DIV_STEPS;
    localparam int RS  = tppg_pkg::SQRT_STEPS;
    localparam int LAT = tppg_pkg::LATENCY;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]                    pattern_kind_reg;
    logic [1:0]                    pixel_format_reg;
    logic [DW-1:0]                 image_width_reg;
    logic [DW-1:0]                 image_height_reg;
    logic [tppg_pkg::COLOR_W-1:0]  first_color_reg;
    logic [tppg_pkg::COLOR_W-1:0]  second_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_kind_reg <= tppg_pkg::RST_PATTERN_KIND;
            pixel_format_reg <= tppg_pkg::RST_PIXEL_FORMAT;
            image_width_reg  <= tppg_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= tppg_pkg::RST_IMAGE_HEIGHT;
            first_color_reg  <= tppg_pkg::RST_FIRST_COLOR;
            second_color_reg <= tppg_pkg::RST_SECOND_COLOR;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tppg_pkg::REG_PATTERN_KIND: pattern_kind_reg <= cfg_data[1:0];
                tppg_pkg::REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[1:0];
                tppg_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DW-1:0];
                tppg_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DW-1:0];
                tppg_pkg::REG_FIRST_COLOR:  first_color_reg  <= cfg_data;
                tppg_pkg::REG_SECOND_COLOR: second_color_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective dimensions, clamped to 1..MAX_DIMENSION
    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] d);
        logic [DW-1:0] res;
        if (d == '0)
            res = DW'(1);
        else if (int'(d) > MAX_DIMENSION)
            res = DW'(MAX_DIMENSION);
        else
            res = d;
        return res;
    endfunction

    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;

    assign w_eff = clamp_dim(image_width_reg);
    assign h_eff = clamp_dim(image_height_reg);

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Valid pipeline and input stage
    // ------------------------------------------------------------------
    logic [1:LAT]  vld_reg;
    logic [CW-1:0] x1_reg;
    logic [CW-1:0] y1_reg;
    // odd cell flags: bit 2 checker, bit 1 vertical stripe, bit 0 horizontal stripe
    logic [2:0]    odd_reg [tppg_pkg::ST_IN:tppg_pkg::ST_ALPHA];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {start, vld_reg[1:LAT-1]};
    end

    always_ff @(posedge clk)
    begin
        x1_reg <= pixel_x;
        y1_reg <= pixel_y;
        odd_reg[tppg_pkg::ST_IN] <= {pixel_x[3] ^ pixel_y[3], pixel_x[2], pixel_y[2]};
        for (int i = tppg_pkg::ST_IN; i < tppg_pkg::ST_ALPHA; i++)
            odd_reg[i+1] <= odd_reg[i];
    end

    // ------------------------------------------------------------------
    // Alpha path: squared offsets from the centre
    // ------------------------------------------------------------------
    logic signed [DW+1:0] dx, dy, ndx, ndy;
    logic [DW-1:0]        adx, ady;
    logic [SW-2:0]        dx2_reg, dy2_reg, w2_reg, h2_reg;
    logic [SW-1:0]        d2_reg, m2_reg;

    always_comb
    begin
        dx  = $signed({2'b00, x1_reg, 1'b0}) - $signed({2'b00, w_eff});
        dy  = $signed({2'b00, y1_reg, 1'b0}) - $signed({2'b00, h_eff});
        ndx = -dx;
        ndy = -dy;
        adx = dx[DW+1] ? ndx[DW-1:0] : dx[DW-1:0];
        ady = dy[DW+1] ? ndy[DW-1:0] : dy[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        dx2_reg <= adx * adx;
        dy2_reg <= ady * ady;
        w2_reg  <= w_eff * w_eff;
        h2_reg  <= h_eff * h_eff;
        d2_reg  <= {1'b0, dx2_reg} + {1'b0, dy2_reg};
        m2_reg  <= {1'b0, w2_reg} + {1'b0, h2_reg};
    end

    // ------------------------------------------------------------------
    // Alpha path: restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [SW-1:0] div_rem_in  [0:DS-1];
    logic [SW-1:0] div_m_in    [0:DS-1];
    logic [QW-1:0] div_quo_in  [0:DS-1];
    logic [1:0]    div_nb_in   [0:DS-1];
    logic          div_sat_in  [0:DS-1];
    logic [SW-1:0] div_rem_next[0:DS-1];
    logic [QW-1:0] div_quo_next[0:DS-1];
    logic [1:0]    div_nb_next [0:DS-1];
    logic [SW-1:0] div_rem_reg [1:DS];
    logic [SW-1:0] div_m_reg   [1:DS];
    logic [QW-1:0] div_quo_reg [1:DS];
    logic [1:0]    div_nb_reg  [1:DS];
    logic          div_sat_reg [1:DS];

    for (genvar k = 0; k < DS; k++)
    begin : g_div
        logic [SW:0] trial;
        logic [SW:0] diff;
        logic        ge;

        if (k == 0)
        begin : g_first
            // quotient would reach 2^34 when D2 >= 4 M2: alpha saturates to zero
            assign div_rem_in[k] = {2'b00, d2_reg[SW-1:2]};
            assign div_nb_in[k]  = d2_reg[1:0];
            assign div_m_in[k]   = m2_reg;
            assign div_quo_in[k] = '0;
            assign div_sat_in[k] = ({2'b00, d2_reg} >= {m2_reg, 2'b00});
        end
        else
        begin : g_rest
            assign div_rem_in[k] = div_rem_reg[k];
            assign div_nb_in[k]  = div_nb_reg[k];
            assign div_m_in[k]   = div_m_reg[k];
            assign div_quo_in[k] = div_quo_reg[k];
            assign div_sat_in[k] = div_sat_reg[k];
        end

        assign trial           = {div_rem_in[k], div_nb_in[k][1]};
        assign ge              = (trial >= {1'b0, div_m_in[k]});
        assign diff            = trial - {1'b0, div_m_in[k]};
        assign div_rem_next[k] = ge ? diff[SW-1:0] : trial[SW-1:0];
        assign div_quo_next[k] = {div_quo_in[k][QW-2:0], ge};
        assign div_nb_next[k]  = {div_nb_in[k][0], 1'b0};

        always_ff @(posedge clk)
        begin
            div_rem_reg[k+1] <= div_rem_next[k];
            div_m_reg[k+1]   <= div_m_in[k];
            div_quo_reg[k+1] <= div_quo_next[k];
            div_nb_reg[k+1]  <= div_nb_next[k];
            div_sat_reg[k+1] <= div_sat_in[k];
        end
    end

    // ------------------------------------------------------------------
    // Alpha path: digit-by-digit square root, two radicand bits per stage
    // ------------------------------------------------------------------
    logic [MW-1:0] sq_rem_in   [0:RS-1];
    logic [RW-1:0] sq_root_in  [0:RS-1];
    logic [QW-1:0] sq_rad_in   [0:RS-1];
    logic          sq_sat_in   [0:RS-1];
    logic [MW-1:0] sq_rem_next [0:RS-1];
    logic [RW-1:0] sq_root_next[0:RS-1];
    logic [MW-1:0] sq_rem_reg  [1:RS];
    logic [RW-1:0] sq_root_reg [1:RS];
    logic [QW-1:0] sq_rad_reg  [1:RS];
    logic          sq_sat_reg  [1:RS];

    for (genvar k = 0; k < RS; k++)
    begin : g_root
        logic [MW-1:0] remx;
        logic [MW-1:0] trial;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign sq_rem_in[k]  = '0;
            assign sq_root_in[k] = '0;
            assign sq_rad_in[k]  = div_quo_reg[DS];
            assign sq_sat_in[k]  = div_sat_reg[DS];
        end
        else
        begin : g_rest
            assign sq_rem_in[k]  = sq_rem_reg[k];
            assign sq_root_in[k] = sq_root_reg[k];
            assign sq_rad_in[k]  = sq_rad_reg[k];
            assign sq_sat_in[k]  = sq_sat_reg[k];
        end

        assign remx            = {sq_rem_in[k][MW-3:0], sq_rad_in[k][QW-1:QW-2]};
        assign trial           = {1'b0, sq_root_in[k], 2'b01};
        assign ge              = (remx >= trial);
        assign sq_rem_next[k]  = ge ? (remx - trial) : remx;
        assign sq_root_next[k] = {sq_root_in[k][RW-2:0], ge};

        always_ff @(posedge clk)
        begin
            sq_rem_reg[k+1]  <= sq_rem_next[k];
            sq_root_reg[k+1] <= sq_root_next[k];
            sq_rad_reg[k+1]  <= {sq_rad_in[k][QW-3:0], 2'b00};
            sq_sat_reg[k+1]  <= sq_sat_in[k];
        end
    end

    // Alpha = (98304 - ratio) / 512, zero at or beyond the floor
    logic [RW-1:0] alpha_diff;
    logic [7:0]    alpha_next;
    logic [7:0]    alpha_reg;

    always_comb
    begin
        alpha_diff = tppg_pkg::RATIO_FLOOR - sq_root_reg[RS];
        if (sq_sat_reg[RS] || (sq_root_reg[RS] >= tppg_pkg::RATIO_FLOOR))
            alpha_next = '0;
        else
            alpha_next = alpha_diff[RW-1:RW-8];
    end

    always_ff @(posedge clk)
    begin
        alpha_reg <= alpha_next;
    end

    // ------------------------------------------------------------------
    // Hue path: x * 2^16 / w and y * 2^16 / h, low 16 quotient bits kept
    // ------------------------------------------------------------------
    logic [DW-1:0] hx_rem_in [0:HS-1];
    logic [DW-1:0] hy_rem_in [0:HS-1];
    logic [FW-1:0] hx_quo_in [0:HS-1];
    logic [FW-1:0] hy_quo_in [0:HS-1];
    logic [CW-1:0] hx_num_in [0:HS-1];
    logic [CW-1:0] hy_num_in [0:HS-1];
    logic [DW-1:0] hx_rem_next[0:HS-1];
    logic [DW-1:0] hy_rem_next[0:HS-1];
    logic [DW-1:0] hx_rem_reg [1:HS];
    logic [DW-1:0] hy_rem_reg [1:HS];
    logic [FW-1:0] hx_quo_reg [1:HS];
    logic [FW-1:0] hy_quo_reg [1:HS];
    logic [CW-1:0] hx_num_reg [1:HS];
    logic [CW-1:0] hy_num_reg [1:HS];

    for (genvar k = 0; k < HS; k++)
    begin : g_hue_div
        logic [DW:0] tx, ty, dfx, dfy;
        logic        gex, gey;

        if (k == 0)
        begin : g_first
            assign hx_rem_in[k] = '0;
            assign hy_rem_in[k] = '0;
            assign hx_quo_in[k] = '0;
            assign hy_quo_in[k] = '0;
            assign hx_num_in[k] = x1_reg;
            assign hy_num_in[k] = y1_reg;
        end
        else
        begin : g_rest
            assign hx_rem_in[k] = hx_rem_reg[k];
            assign hy_rem_in[k] = hy_rem_reg[k];
            assign hx_quo_in[k] = hx_quo_reg[k];
            assign hy_quo_in[k] = hy_quo_reg[k];
            assign hx_num_in[k] = hx_num_reg[k];
            assign hy_num_in[k] = hy_num_reg[k];
        end

        assign tx  = {hx_rem_in[k], hx_num_in[k][CW-1]};
        assign ty  = {hy_rem_in[k], hy_num_in[k][CW-1]};
        assign gex = (tx >= {1'b0, w_eff});
        assign gey = (ty >= {1'b0, h_eff});
        assign dfx = tx - {1'b0, w_eff};
        assign dfy = ty - {1'b0, h_eff};
        assign hx_rem_next[k] = gex ? dfx[DW-1:0] : tx[DW-1:0];
        assign hy_rem_next[k] = gey ? dfy[DW-1:0] : ty[DW-1:0];

        always_ff @(posedge clk)
        begin
            hx_rem_reg[k+1] <= hx_rem_next[k];
            hy_rem_reg[k+1] <= hy_rem_next[k];
            hx_quo_reg[k+1] <= {hx_quo_in[k][FW-2:0], gex};
            hy_quo_reg[k+1] <= {hy_quo_in[k][FW-2:0], gey};
            hx_num_reg[k+1] <= {hx_num_in[k][CW-2:0], 1'b0};
            hy_num_reg[k+1] <= {hy_num_in[k][CW-2:0], 1'b0};
        end
    end

    // Hue wraps modulo one turn; six sectors
    logic [FW-1:0] hue_sum;
    logic [FW+2:0] hue6;
    logic [2:0]    hue_sector_reg;
    logic [FW-1:0] hue_frac_reg;

    always_comb
    begin
        hue_sum = hx_quo_reg[HS] + hy_quo_reg[HS];
        hue6    = {3'b000, hue_sum} * 19'd6;
    end

    always_ff @(posedge clk)
    begin
        hue_sector_reg <= hue6[FW+2:FW];
        hue_frac_reg   <= hue6[FW-1:0];
    end

    // Rising and falling ramps
    logic [FW:0]   frac_inv;
    logic [23:0]   up_prod, down_prod;
    logic [7:0]    ramp_up_reg, ramp_down_reg;
    logic [2:0]    ramp_sector_reg;

    always_comb
    begin
        frac_inv  = 17'h10000 - {1'b0, hue_frac_reg};
        up_prod   = {8'h00, hue_frac_reg} * 24'd255;
        down_prod = {7'h00, frac_inv} * 24'd255;
    end

    always_ff @(posedge clk)
    begin
        ramp_up_reg     <= up_prod[23:16];
        ramp_down_reg   <= down_prod[23:16];
        ramp_sector_reg <= hue_sector_reg;
    end

    // Sector to colour
    tppg_pkg::rgb_t hue_rgb_next;
    tppg_pkg::rgb_t hue_rgb_reg [tppg_pkg::ST_HUE_RGB:tppg_pkg::ST_ALPHA];

    always_comb
    begin
        case (ramp_sector_reg)
            3'd0:    hue_rgb_next = '{r: 8'hFF,          g: ramp_up_reg,   b: 8'h00};
            3'd1:    hue_rgb_next = '{r: ramp_down_reg,  g: 8'hFF,         b: 8'h00};
            3'd2:    hue_rgb_next = '{r: 8'h00,          g: 8'hFF,         b: ramp_up_reg};
            3'd3:    hue_rgb_next = '{r: 8'h00,          g: ramp_down_reg, b: 8'hFF};
            3'd4:    hue_rgb_next = '{r: ramp_up_reg,    g: 8'h00,         b: 8'hFF};
            default: hue_rgb_next = '{r: 8'hFF,          g: 8'h00,         b: ramp_down_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        hue_rgb_reg[tppg_pkg::ST_HUE_RGB] <= hue_rgb_next;
        for (int i = tppg_pkg::ST_HUE_RGB; i < tppg_pkg::ST_ALPHA; i++)
            hue_rgb_reg[i+1] <= hue_rgb_reg[i];
    end

    // ------------------------------------------------------------------
    // Output stage: pattern select and packing
    // ------------------------------------------------------------------
    logic                          cell_odd;
    logic [tppg_pkg::COLOR_W-1:0]  cell_color;
    tppg_pkg::rgb_t                pix;
    logic [7:0]                    pix_alpha;
    logic [tppg_pkg::WORD_W-1:0]   pixel_word_next, pixel_word_reg;
    logic [tppg_pkg::COUNT_W-1:0]  byte_count_next, byte_count_reg;

    always_comb
    begin
        case (pattern_kind_reg)
            tppg_pkg::PAT_CHECKER: cell_odd = odd_reg[tppg_pkg::ST_ALPHA][2];
            tppg_pkg::PAT_VSTRIPE: cell_odd = odd_reg[tppg_pkg::ST_ALPHA][1];
            default:               cell_odd = odd_reg[tppg_pkg::ST_ALPHA][0];
        endcase
        cell_color = cell_odd ? second_color_reg : first_color_reg;

        if (pattern_kind_reg == tppg_pkg::PAT_HUE)
        begin
            pix       = hue_rgb_reg[tppg_pkg::ST_ALPHA];
            pix_alpha = tppg_pkg::ALPHA_FULL;
        end
        else
        begin
            pix       = cell_color;
            pix_alpha = alpha_reg;
        end

        case (pixel_format_reg)
            tppg_pkg::FMT_RGB332:
            begin
                pixel_word_next = {24'h0, pix.r[7:5], pix.g[7:5], pix.b[7:6]};
                byte_count_next = tppg_pkg::BYTES_RGB332;
            end
            tppg_pkg::FMT_RGB565:
            begin
                pixel_word_next = {16'h0, pix.r[7:3], pix.g[7:2], pix.b[7:3]};
                byte_count_next = tppg_pkg::BYTES_RGB565;
            end
            tppg_pkg::FMT_RGB888:
            begin
                pixel_word_next = {8'h0, pix.b, pix.g, pix.r};
                byte_count_next = tppg_pkg::BYTES_RGB888;
            end
            default:
            begin
                pixel_word_next = {pix_alpha, pix.b, pix.g, pix.r};
                byte_count_next = tppg_pkg::BYTES_RGBA8;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pixel_word_reg <= pixel_word_next;
        byte_count_reg <= byte_count_next;
    end

    assign done       = vld_reg[LAT];
    assign pixel_word = pixel_word_reg;
    assign byte_count = byte_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted pixel did not appear after the pipeline latency");

    a_count_set: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (byte_count != '0))
        else $error("result beat with zero byte count");

    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (byte_count == tppg_pkg::BYTES_RGB332)) |-> (pixel_word[31:8] == '0))
        else $error("one-byte pixel has stray upper bits");

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[tppg_pkg::ST_ALPHA] |-> (alpha_reg <= tppg_pkg::ALPHA_MAX))
        else $error("radial alpha above centre value");

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[tppg_pkg::ST_HUE_SUM] |-> (hue_sector_reg <= 3'd5))
        else $error("hue sector out of range");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none

module tb;

    localparam int  CLK_HALF   = 2;
    localparam int  DRAIN_CYC  = tppg_pkg::LATENCY + 8;
    localparam longint CYCLE_LIMIT = 400000;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write;
    logic [tppg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tppg_pkg::COLOR_W-1:0]   cfg_data;
    logic                           start;
    logic                           busy;
    logic [tppg_pkg::COORD_W-1:0]   pixel_x;
    logic [tppg_pkg::COORD_W-1:0]   pixel_y;
    logic                           done;
    logic [tppg_pkg::WORD_W-1:0]    pixel_word;
    logic [tppg_pkg::COUNT_W-1:0]   byte_count;

    // Expected pixel beats, oldest first
    typedef struct {
        logic [tppg_pkg::WORD_W-1:0]  word;
        logic [tppg_pkg::COUNT_W-1:0] count;
        logic [tppg_pkg::COORD_W-1:0] x;
        logic [tppg_pkg::COORD_W-1:0] y;
    } pixel_beat_t;

    pixel_beat_t pending_pixels[$];

    // Shadow copy of the register file
    logic [1:0]                   sh_pattern;
    logic [1:0]                   sh_format;
    logic [tppg_pkg::DIM_W-1:0]   sh_width;
    logic [tppg_pkg::DIM_W-1:0]   sh_height;
    logic [tppg_pkg::COLOR_W-1:0] sh_first;
    logic [tppg_pkg::COLOR_W-1:0] sh_second;

    int     error_count;
    longint cycle_count;
    int     idle_pct;

    test_pattern_pixel_generator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .done       (done),
        .pixel_word (pixel_word),
        .byte_count (byte_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic int unsigned clamp_dim(input logic [tppg_pkg::DIM_W-1:0] d);
        if (d < 1)
            return 1;
        if (d > tppg_pkg::MAX_DIMENSION_DEF)
            return tppg_pkg::MAX_DIMENSION_DEF;
        return 32'(d);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Alpha falls from 192 at the centre to 64 at the corners, saturating at 0
    function automatic logic [7:0] centre_alpha(input int unsigned x, input int unsigned y,
                                                input int unsigned w, input int unsigned h);
        longint      dx;
        longint      dy;
        logic [63:0] d2;
        logic [63:0] m2;
        logic [63:0] ratio;
        dx    = 2 * longint'(x) - longint'(w);
        dy    = 2 * longint'(y) - longint'(h);
        d2    = dx * dx + dy * dy;
        m2    = longint'(w) * w + longint'(h) * h;
        ratio = int_sqrt((d2 << 32) / m2);
        if (ratio >= 64'd98304)
            return 8'd0;
        return 8'((64'd98304 - ratio) >> 9);
    endfunction

    function automatic tppg_pkg::rgb_t hue_ramp(input int unsigned x, input int unsigned y,
                                                input int unsigned w, input int unsigned h);
        logic [31:0]    fx;
        logic [31:0]    fy;
        logic [31:0]    hue;
        logic [31:0]    h6;
        logic [31:0]    frac;
        logic [7:0]     up;
        logic [7:0]     down;
        tppg_pkg::rgb_t c;
        fx   = (x << 16) / w;
        fy   = (y << 16) / h;
        hue  = (fx + fy) & 32'hFFFF;
        h6   = hue * 6;
        frac = h6 & 32'hFFFF;
        up   = 8'((frac * 255) >> 16);
        down = 8'(((32'h10000 - frac) * 255) >> 16);
        case (h6 >> 16)
            0:       c = '{8'd255, up, 8'd0};
            1:       c = '{down, 8'd255, 8'd0};
            2:       c = '{8'd0, 8'd255, up};
            3:       c = '{8'd0, down, 8'd255};
            4:       c = '{up, 8'd0, 8'd255};
            default: c = '{8'd255, 8'd0, down};
        endcase
        return c;
    endfunction

    // Packed pixel for one coordinate under the shadow registers
    function automatic pixel_beat_t predict_pixel(input logic [tppg_pkg::COORD_W-1:0] x,
                                                  input logic [tppg_pkg::COORD_W-1:0] y);
        int unsigned                  w;
        int unsigned                  h;
        tppg_pkg::rgb_t               c;
        logic [7:0]                   a;
        logic                         even;
        logic [tppg_pkg::COLOR_W-1:0] col;
        pixel_beat_t                  p;
        w = clamp_dim(sh_width);
        h = clamp_dim(sh_height);
        if (sh_pattern == tppg_pkg::PAT_HUE)
        begin
            c = hue_ramp(x, y, w, h);
            a = tppg_pkg::ALPHA_FULL;
        end
        else
        begin
            if (sh_pattern == tppg_pkg::PAT_CHECKER)
                even = (((x >> 3) + (y >> 3)) & 1) == 0;
            else if (sh_pattern == tppg_pkg::PAT_VSTRIPE)
                even = x[2] == 1'b0;
            else
                even = y[2] == 1'b0;
            col = even ? sh_first : sh_second;
            c   = col;
            a   = centre_alpha(x, y, w, h);
        end
        p.x = x;
        p.y = y;
        case (sh_format)
            tppg_pkg::FMT_RGB332:
            begin
                p.word  = 32'((c.r & 8'hE0) | ((c.g & 8'hE0) >> 3) | ((c.b & 8'hC0) >> 6));
                p.count = tppg_pkg::BYTES_RGB332;
            end
            tppg_pkg::FMT_RGB565:
            begin
                p.word  = (32'(c.r & 8'hF8) << 8) | (32'(c.g & 8'hFC) << 3) | 32'(c.b >> 3);
                p.count = tppg_pkg::BYTES_RGB565;
            end
            tppg_pkg::FMT_RGB888:
            begin
                p.word  = {8'd0, c.b, c.g, c.r};
                p.count = tppg_pkg::BYTES_RGB888;
            end
            default:
            begin
                p.word  = {a, c.b, c.g, c.r};
                p.count = tppg_pkg::BYTES_RGBA8;
            end
        endcase
        return p;
    endfunction

    // Accepted coordinates go straight into the expectation queue
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            pending_pixels.push_back(predict_pixel(pixel_x, pixel_y));
    end

    // Result checker
    always @(posedge clk)
    begin
        pixel_beat_t exp_px;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel beat word=%h count=%0d",
                         $time, pixel_word, byte_count);
                error_count++;
            end
            else
            begin
                exp_px = pending_pixels.pop_front();
                if (pixel_word !== exp_px.word)
                begin
                    $display("%0t: pixel_word (%0d,%0d) expected %h actual %h",
                             $time, exp_px.x, exp_px.y, exp_px.word, pixel_word);
                    error_count++;
                end
                if (byte_count !== exp_px.count)
                begin
                    $display("%0t: byte_count (%0d,%0d) expected %0d actual %0d",
                             $time, exp_px.x, exp_px.y, exp_px.count, byte_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Write one register; cfg_write is left high for back-to-back writes
    task automatic write_reg(input logic [tppg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tppg_pkg::COLOR_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            tppg_pkg::REG_PATTERN_KIND: sh_pattern = val[1:0];
            tppg_pkg::REG_PIXEL_FORMAT: sh_format  = val[1:0];
            tppg_pkg::REG_IMAGE_WIDTH:  sh_width   = val[tppg_pkg::DIM_W-1:0];
            tppg_pkg::REG_IMAGE_HEIGHT: sh_height  = val[tppg_pkg::DIM_W-1:0];
            tppg_pkg::REG_FIRST_COLOR:  sh_first   = val;
            tppg_pkg::REG_SECOND_COLOR: sh_second  = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [1:0] pat, input logic [1:0] fmt,
                                  input logic [tppg_pkg::DIM_W-1:0] w,
                                  input logic [tppg_pkg::DIM_W-1:0] h,
                                  input logic [tppg_pkg::COLOR_W-1:0] c0,
                                  input logic [tppg_pkg::COLOR_W-1:0] c1);
        wait_idle();
        write_reg(tppg_pkg::REG_PATTERN_KIND, tppg_pkg::COLOR_W'(pat));
        write_reg(tppg_pkg::REG_PIXEL_FORMAT, tppg_pkg::COLOR_W'(fmt));
        write_reg(tppg_pkg::REG_IMAGE_WIDTH, tppg_pkg::COLOR_W'(w));
        write_reg(tppg_pkg::REG_IMAGE_HEIGHT, tppg_pkg::COLOR_W'(h));
        write_reg(tppg_pkg::REG_FIRST_COLOR, c0);
        write_reg(tppg_pkg::REG_SECOND_COLOR, c1);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Send one coordinate beat; each cycle before it idles with chance idle_pct
    task automatic send_pixel(input logic [tppg_pkg::COORD_W-1:0] x,
                              input logic [tppg_pkg::COORD_W-1:0] y);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [tppg_pkg::DIM_W-1:0] pick_dim();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd1024;
            3:       return 11'd2047;
            4, 5, 6: return tppg_pkg::DIM_W'($urandom_range(2, 64));
            default: return tppg_pkg::DIM_W'($urandom_range(0, 2047));
        endcase
    endfunction

    // Reset values, sampled over a small image with a gap pattern
    task automatic test_reset_values();
        idle_pct = 30;
        for (int i = 0; i < 8; i++)
            send_pixel(tppg_pkg::COORD_W'($urandom_range(0, 31)),
                       tppg_pkg::COORD_W'($urandom_range(0, 31)));
    endtask

    // Corners, centre, far outside, each pattern and format, clamped dimensions
    task automatic test_directed();
        idle_pct = 0;
        for (int k = 0; k < 4; k++)
        begin
            apply_settings(2'(k), 2'(3 - k), 11'd32, 11'd24, 24'hFFFFFF, 24'h000000);
            send_pixel(10'd0, 10'd0);
            send_pixel(10'd16, 10'd12);
            send_pixel(10'd31, 10'd23);
            send_pixel(10'd1023, 10'd1023);
            send_pixel(10'd4, 10'd8);
        end
        // zero size clamps up, oversize clamps down
        apply_settings(tppg_pkg::PAT_HUE, tppg_pkg::FMT_RGBA8, 11'd0, 11'd2047,
                       24'h123456, 24'hABCDEF);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd512);
        apply_settings(tppg_pkg::PAT_CHECKER, tppg_pkg::FMT_RGBA8, 11'd1024, 11'd0,
                       24'hA5A5A5, 24'h5A5A5A);
        send_pixel(10'd512, 10'd0);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
    endtask

    // Random settings, mostly in-image coordinates with some anywhere
    task automatic test_random_phase(input int pct, input int n_settings, input int n_items);
        int unsigned w;
        int unsigned h;
        idle_pct = pct;
        for (int s = 0; s < n_settings; s++)
        begin
            apply_settings(2'($urandom_range(3)), 2'($urandom_range(3)), pick_dim(), pick_dim(),
                           tppg_pkg::COLOR_W'($urandom), tppg_pkg::COLOR_W'($urandom));
            w = clamp_dim(sh_width);
            h = clamp_dim(sh_height);
            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(3) != 0)
                    send_pixel(tppg_pkg::COORD_W'($urandom_range(0, w - 1)),
                               tppg_pkg::COORD_W'($urandom_range(0, h - 1)));
                else
                    send_pixel(tppg_pkg::COORD_W'($urandom), tppg_pkg::COORD_W'($urandom));
            end
        end
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        idle_pct    = 0;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = tppg_pkg::REG_PATTERN_KIND;
        cfg_data    = '0;
        start       = 1'b0;
        pixel_x     = '0;
        pixel_y     = '0;
        sh_pattern  = tppg_pkg::RST_PATTERN_KIND;
        sh_format   = tppg_pkg::RST_PIXEL_FORMAT;
        sh_width    = tppg_pkg::RST_IMAGE_WIDTH;
        sh_height   = tppg_pkg::RST_IMAGE_HEIGHT;
        sh_first    = tppg_pkg::RST_FIRST_COLOR;
        sh_second   = tppg_pkg::RST_SECOND_COLOR;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed();
        test_random_phase(21, 5, 55);
        test_random_phase(72, 5, 55);
        test_random_phase(0, 5, 55);
        wait_idle();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
